[design/wlqe_pkg.sv]
`timescale 1ns / 1ps
package wlqe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 16;
  // quotient of a unit direction component, magnitude at most 1.0
  localparam int QBITS      = FRAC_BITS + 1;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_cmd_t;

  // triangle corners of the quad: 0,1,2 and 1,3,2
  function automatic logic [1:0] corner(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

[design/wlqe_iter.sv]
`timescale 1ns / 1ps
module wlqe_iter import wlqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_cmd_t   cmd,
  input  logic [61:0] radicand,
  input  logic [29:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  logic             busy;
  iter_op_t         op;
  logic [63:0]      v;
  logic [63:0]      r;
  logic [63:0]      bitr;
  logic [31:0]      rem;
  logic [QBITS-1:0] nb;
  logic [QBITS-1:0] q;
  logic [5:0]       cnt;

  logic [31:0] t;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [64:0] diff;
  logic        ge;

  // one shared compare and subtract serves both the root and the divide
  always_comb begin
    t    = {rem[30:0], nb[QBITS-1]};
    opa  = (op == OP_SQRT) ? v : {32'd0, t};
    opb  = (op == OP_SQRT) ? (r + bitr) : {32'd0, divisor};
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        v    <= 64'(radicand);
        r    <= '0;
        bitr <= 64'd1 << 62;
        rem  <= 32'(dividend >> 1);
        nb   <= {dividend[0], {FRAC_BITS{1'b0}}};
        q    <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (op == OP_SQRT) begin
          if (ge) begin
            v <= diff[63:0];
            r <= (r >> 1) + bitr;
          end else begin
            r <= r >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (ge) begin
            rem <= diff[31:0];
          end else begin
            rem <= t;
          end
          q   <= {q[QBITS-2:0], ge};
          nb  <= nb << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QBITS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = (op == OP_SQRT) ? r[31:0] : 32'(q);

endmodule

[design/wide_line_quad_expansion.sv]
`timescale 1ns / 1ps
// Expands one line transaction into four vertices and six triangle indices.
// A line passes these steps after acceptance before its first result is
// offered: one-bit normalization shifts of the delta, squaring on the shared
// multiplier, the bit-serial square root and three bit-serial divides in the
// shared root/divide unit, offset products on the shared multiplier and a
// load of the result register. The ten results follow in order and are held
// while the output is stalled. A zero-length line skips the arithmetic. An
// end-of-frame transaction gives no result. Input stall stays high while a
// line is in flight.
module wide_line_quad_expansion import wlqe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic        [30:0] line_width,
  input  logic        [15:0] color_r,
  input  logic        [15:0] color_g,
  input  logic        [15:0] color_b,
  input  logic        [15:0] color_a,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               item_kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic        [15:0] out_r,
  output logic        [15:0] out_g,
  output logic        [15:0] out_b,
  output logic        [15:0] out_a,
  output logic        [15:0] vertex_index,
  output logic               last
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_NORM      = 9'b000000010,
    S_SQ        = 9'b000000100,
    S_SQRT_GO   = 9'b000001000,
    S_SQRT_WAIT = 9'b000010000,
    S_DIV_GO    = 9'b000100000,
    S_DIV_WAIT  = 9'b001000000,
    S_OFS       = 9'b010000000,
    S_EMIT      = 9'b100000000
  } state_t;

  state_t                  st;
  logic signed [31:0]      sv [3];
  logic signed [31:0]      ev [3];
  logic [32:0]             av [3];
  logic                    dneg [3];
  logic [32:0]             maxa;
  logic [30:0]             w;
  logic [15:0]             col [4];
  logic [31:0]             len;
  logic [QBITS-1:0]        m [3];
  logic signed [31:0]      o [3];
  logic [61:0]             sum;
  logic [63:0]             prod;
  logic [1:0]              idx;
  logic [3:0]              cnt;
  logic [INDEX_BITS-1:0]   vertex_base;

  logic signed [32:0]      d [3];
  logic [32:0]             da [3];
  logic [32:0]             dmax;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [1:0]              sel;
  logic                    swap;
  logic [QBITS-1:0]        cm [3];
  logic                    cneg [3];
  logic [31:0]             omag;
  logic                    accept;
  logic                    out_free;
  iter_cmd_t               cmd;
  logic                    it_done;
  logic [31:0]             it_result;
  logic signed [31:0]      vpos [3];
  logic [INDEX_BITS-1:0]   vidx;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] y;
    if (x > 33'sh0_7FFF_FFFF) begin
      y = 32'sh7FFF_FFFF;
    end else if (x < -33'sh0_8000_0000) begin
      y = 32'sh8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  assign in_stall = (st != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    d[0] = 33'(end_x) - 33'(start_x);
    d[1] = 33'(end_y) - 33'(start_y);
    d[2] = 33'(end_z) - 33'(start_z);
    for (int i = 0; i < 3; i++) begin
      da[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
    end
    dmax = da[0];
    if (da[1] > dmax) begin
      dmax = da[1];
    end
    if (da[2] > dmax) begin
      dmax = da[2];
    end
  end

  // side vector: cross with z when the direction is close to the y axis
  always_comb begin
    swap = (32'(m[1]) * 32'd20) >= (32'd19 << FRAC_BITS);
    if (swap) begin
      cm[0] = m[1];  cneg[0] = dneg[1];
      cm[1] = m[0];  cneg[1] = !dneg[0];
      cm[2] = '0;    cneg[2] = 1'b0;
    end else begin
      cm[0] = m[2];  cneg[0] = !dneg[2];
      cm[1] = '0;    cneg[1] = 1'b0;
      cm[2] = m[0];  cneg[2] = dneg[0];
    end
  end

  always_comb begin
    sel = (idx == 2'd3) ? 2'd2 : idx;
    if (st == S_OFS) begin
      mul_a = 32'(cm[sel]);
      mul_b = 32'(w);
    end else begin
      mul_a = av[sel][31:0];
      mul_b = av[sel][31:0];
    end
    omag = 32'(prod >> (FRAC_BITS + 1));
  end

  always_comb begin
    cmd.start = (st == S_SQRT_GO) || (st == S_DIV_GO);
    cmd.op    = (st == S_SQRT_GO) ? OP_SQRT : OP_DIV;
  end

  wlqe_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .radicand (sum),
    .dividend (av[sel][29:0]),
    .divisor  (len),
    .done     (it_done),
    .result   (it_result)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cnt[0]) begin
        vpos[i] = sat33(33'(cnt[1] ? ev[i] : sv[i]) - 33'(o[i]));
      end else begin
        vpos[i] = sat33(33'(cnt[1] ? ev[i] : sv[i]) + 33'(o[i]));
      end
    end
    vidx = vertex_base + INDEX_BITS'(corner(3'(cnt - 4'd4)));
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      vertex_base <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      cnt         <= '0;
    end else begin
      if (st == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              vertex_base <= '0;
            end else begin
              sv[0] <= start_x; sv[1] <= start_y; sv[2] <= start_z;
              ev[0] <= end_x;   ev[1] <= end_y;   ev[2] <= end_z;
              w      <= line_width;
              col[0] <= color_r; col[1] <= color_g;
              col[2] <= color_b; col[3] <= color_a;
              for (int i = 0; i < 3; i++) begin
                av[i]   <= da[i];
                dneg[i] <= d[i][32];
                o[i]    <= '0;
              end
              maxa <= dmax;
              cnt  <= '0;
              idx  <= '0;
              // zero-length line keeps a zero offset
              st   <= (dmax == '0) ? S_EMIT : S_NORM;
            end
          end
        end
        S_NORM: begin
          if (maxa[32:30] != '0) begin
            maxa <= maxa >> 1;
            for (int i = 0; i < 3; i++) begin
              av[i] <= av[i] >> 1;
            end
          end else if (!maxa[29]) begin
            maxa <= maxa << 1;
            for (int i = 0; i < 3; i++) begin
              av[i] <= av[i] << 1;
            end
          end else begin
            idx <= '0;
            st  <= S_SQ;
          end
        end
        S_SQ: begin
          idx <= idx + 2'd1;
          if (idx == 2'd1) begin
            sum <= prod[61:0];
          end else if (idx != 2'd0) begin
            sum <= sum + prod[61:0];
          end
          if (idx == 2'd3) begin
            st <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: begin
          st <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (it_done) begin
            len <= it_result;
            idx <= '0;
            st  <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          st <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (it_done) begin
            m[sel] <= it_result[QBITS-1:0];
            if (idx == 2'd2) begin
              idx <= '0;
              st  <= S_OFS;
            end else begin
              idx <= idx + 2'd1;
              st  <= S_DIV_GO;
            end
          end
        end
        S_OFS: begin
          idx <= idx + 2'd1;
          if (idx != 2'd0) begin
            o[2'(idx - 2'd1)] <= cneg[2'(idx - 2'd1)] ? -omag : omag;
          end
          if (idx == 2'd3) begin
            cnt <= '0;
            st  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cnt <= cnt + 4'd1;
            if (cnt == 4'd9) begin
              vertex_base <= vertex_base + INDEX_BITS'(4);
              st          <= S_IDLE;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (st == S_EMIT && out_free) begin
      if (cnt < 4'd4) begin
        item_kind    <= 1'b0;
        pos_x        <= vpos[0];
        pos_y        <= vpos[1];
        pos_z        <= vpos[2];
        out_r        <= col[0];
        out_g        <= col[1];
        out_b        <= col[2];
        out_a        <= col[3];
        vertex_index <= '0;
        last         <= 1'b0;
      end else begin
        item_kind    <= 1'b1;
        pos_x        <= '0;
        pos_y        <= '0;
        pos_z        <= '0;
        out_r        <= '0;
        out_g        <= '0;
        out_b        <= '0;
        out_a        <= '0;
        vertex_index <= 16'(vidx);
        last         <= (cnt == 4'd9);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_clears_base: assert property (@(posedge clk) disable iff (rst)
    accept && mode |=> vertex_base == '0)
    else $error("end of frame did not clear vertex base");

  a_last_is_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> item_kind)
    else $error("last flag on a vertex result");

  a_vertex_no_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_kind |-> vertex_index == '0 && !last)
    else $error("vertex result carries an index");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    it_done |-> (st == S_SQRT_WAIT || st == S_DIV_WAIT))
    else $error("iterative unit finished outside a wait state");
`endif

endmodule

[test/wide_line_quad_expansion_tb.sv]
`timescale 1ns / 1ps
module wide_line_quad_expansion_tb;
  import wlqe_pkg::*;

  typedef enum logic {MODE_LINE = 1'b0, MODE_EOF = 1'b1} line_mode_t;
  typedef enum logic {KIND_VERTEX = 1'b0, KIND_INDEX = 1'b1} result_kind_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [15:0] r;
    logic        [15:0] g;
    logic        [15:0] b;
    logic        [15:0] a;
    logic        [15:0] idx;
    logic               lst;
  } quad_result_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic [30:0] line_width = '0;
  logic [15:0] color_r = '0, color_g = '0, color_b = '0, color_a = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic item_kind;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [15:0] out_r, out_g, out_b, out_a, vertex_index;
  logic last;

  quad_result_t pending_results[$];
  logic [INDEX_BITS-1:0] model_base;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  wide_line_quad_expansion dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_pct > 0) out_stall <= ($urandom_range(99) < stall_pct);
    else out_stall <= 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bitv, x;
    x = v;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected vertices and indices of one line, and advance of the base
  task automatic predict_quad(input logic signed [31:0] s[3], input logic signed [31:0] e[3],
                              input logic [30:0] w, input logic [15:0] col[4]);
    logic signed [63:0] d[3], dir[3], side[3], ofs[3], m;
    logic [63:0] mag[3], maxa, sum, len, prod;
    quad_result_t res;
    logic [1:0] corners[6];
    corners = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2};
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(e[i]) - 64'(s[i]);
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      ofs[i] = 0;
    end
    maxa = mag[0];
    if (mag[1] > maxa) maxa = mag[1];
    if (mag[2] > maxa) maxa = mag[2];
    if (maxa != 0) begin
      while (maxa >= (64'd1 << 30)) begin
        maxa = maxa >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (maxa < (64'd1 << 29)) begin
        maxa = maxa << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        m = (mag[i] << FRAC_BITS) / len;
        dir[i] = d[i] < 0 ? -m : m;
      end
      // near-vertical direction crosses with z instead of y
      if ((dir[1] < 0 ? -dir[1] : dir[1]) * 20 >= (64'sd19 << FRAC_BITS)) begin
        side[0] = dir[1]; side[1] = -dir[0]; side[2] = 0;
      end else begin
        side[0] = -dir[2]; side[1] = 0; side[2] = dir[0];
      end
      for (int i = 0; i < 3; i++) begin
        prod = ((side[i] < 0 ? -side[i] : side[i]) * 64'(w)) >> (FRAC_BITS + 1);
        ofs[i] = side[i] < 0 ? -$signed(prod) : $signed(prod);
      end
    end
    for (int k = 0; k < 4; k++) begin
      res = '0;
      res.kind = KIND_VERTEX;
      res.px = clamp32(64'((k < 2) ? s[0] : e[0]) + ((k & 1) ? -ofs[0] : ofs[0]));
      res.py = clamp32(64'((k < 2) ? s[1] : e[1]) + ((k & 1) ? -ofs[1] : ofs[1]));
      res.pz = clamp32(64'((k < 2) ? s[2] : e[2]) + ((k & 1) ? -ofs[2] : ofs[2]));
      res.r = col[0]; res.g = col[1]; res.b = col[2]; res.a = col[3];
      pending_results.push_back(res);
    end
    for (int k = 0; k < 6; k++) begin
      res = '0;
      res.kind = KIND_INDEX;
      res.idx = 16'(model_base + INDEX_BITS'(corners[k]));
      res.lst = (k == 5);
      pending_results.push_back(res);
    end
    model_base = model_base + INDEX_BITS'(4);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    quad_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", item_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (item_kind !== want.kind) report_mismatch("item_kind", item_kind, want.kind);
        if (pos_x !== want.px) report_mismatch("pos_x", pos_x, want.px);
        if (pos_y !== want.py) report_mismatch("pos_y", pos_y, want.py);
        if (pos_z !== want.pz) report_mismatch("pos_z", pos_z, want.pz);
        if (out_r !== want.r) report_mismatch("out_r", out_r, want.r);
        if (out_g !== want.g) report_mismatch("out_g", out_g, want.g);
        if (out_b !== want.b) report_mismatch("out_b", out_b, want.b);
        if (out_a !== want.a) report_mismatch("out_a", out_a, want.a);
        if (vertex_index !== want.idx) report_mismatch("vertex_index", vertex_index, want.idx);
        if (last !== want.lst) report_mismatch("last", last, want.lst);
      end
    end
  end

  // drive one transaction and hold it until accepted
  // valid is left high afterwards; the next transaction or the idle loop replaces it
  task automatic send_item(input line_mode_t md, input logic signed [31:0] s[3],
                           input logic signed [31:0] e[3], input logic [30:0] w,
                           input logic [15:0] col[4]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
    end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
    line_width <= w;
    color_r <= col[0]; color_g <= col[1]; color_b <= col[2]; color_a <= col[3];
    do @(posedge clk); while (in_stall);
    if (md == MODE_EOF) model_base = '0;
    else predict_quad(s, e, w, col);
  endtask

  task automatic send_line(input logic signed [31:0] s[3], input logic signed [31:0] e[3],
                           input logic [30:0] w, input logic [15:0] col[4]);
    send_item(MODE_LINE, s, e, w, col);
  endtask

  task automatic send_eof();
    logic signed [31:0] z[3];
    logic [15:0] c[4];
    z = '{32'h0, 32'h0, 32'h0};
    c = '{16'h0, 16'h0, 16'h0, 16'h0};
    send_item(MODE_EOF, z, z, 31'h0, c);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(65535)) << 8) - 32'sd8388608;
      2: return $urandom_range(1) ? 32'sh7FFFFFF0 + $urandom_range(15)
                                  : 32'sh80000000 + $urandom_range(15);
      default: return $signed(32'($urandom_range(2047)) << 16) - 32'sd67108864;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] s[3], e[3];
    logic [15:0] c[4];
    c = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A};
    s = '{32'sh00010000, 32'sh00020000, 32'sh00030000};
    e = '{32'sh00050000, 32'sh00020000, 32'sh00030000};
    send_line(s, e, 31'h00020000, c);
    // zero-length segment
    send_line(s, s, 31'h7FFFFFFF, c);
    // near-vertical switches to the z axis
    e = '{32'sh00010000, 32'sh00120000, 32'sh00030000};
    send_line(s, e, 31'h00010000, c);
    e = '{32'sh00011000, 32'shFFF00000, 32'sh00030000};
    send_line(s, e, 31'h00010000, c);
    // extreme endpoints with full width, saturating sums
    s = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    e = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
    send_line(s, e, 31'h7FFFFFFF, c);
    send_line(e, s, 31'h7FFFFFFF, '{16'h0, 16'hFFFF, 16'h0, 16'hFFFF});
    s = '{32'sh7FFFFFFF, 32'sh0, 32'sh0};
    e = '{32'sh7FFFFFFF, 32'sh0, 32'sh00100000};
    send_line(s, e, 31'h7FFFFFFF, c);
    send_line(s, e, 31'h0, c);
    send_eof();
    send_line(e, s, 31'h00008000, c);
  endtask

  task automatic test_random(input int count);
    logic signed [31:0] s[3], e[3];
    logic [15:0] c[4];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0) begin
        send_eof();
      end else begin
        for (int i = 0; i < 3; i++) begin
          s[i] = rand_coord();
          e[i] = $urandom_range(9) == 0 ? s[i] : rand_coord();
        end
        for (int i = 0; i < 4; i++) c[i] = $urandom_range(65535);
        send_line(s, e, $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 20)),
                  c);
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct = stall;
    test_random(count);
  endtask

  initial begin
    int tail;
    model_base = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_phase(0, 0, 30);
    run_phase(54, 0, 30);
    run_phase(0, 54, 30);
    run_phase(9, 9, 30);
    in_valid <= 1'b0;
    stall_pct = 0;
    send_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
